// File: hdl/ols_pkg.sv
// ----------------------------------------------------------------------------
// ols_pkg
// Operation codes, status codes and word layout for the ordered list store.
// ----------------------------------------------------------------------------
package ols_pkg;

    typedef logic [2:0] func_t;
    typedef logic [1:0] status_t;

    localparam func_t FN_APPEND  = 3'd0;
    localparam func_t FN_INSERT  = 3'd1;
    localparam func_t FN_REMOVE  = 3'd2;
    localparam func_t FN_POP     = 3'd3;
    localparam func_t FN_INDEX   = 3'd4;
    localparam func_t FN_COUNT   = 3'd5;
    localparam func_t FN_REVERSE = 3'd6;
    localparam func_t FN_CLEAR   = 3'd7;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_RANGE     = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

    // Field widths of the stream words.
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 8;
    localparam int ITEM_W   = 64;
    localparam int STATUS_W = 2;
    localparam int NUM_W    = 7;

    // Input word: func, position, item_value from bit 0 upward.
    localparam int FUNC_LSB = 0;
    localparam int POS_LSB  = FUNC_LSB + FUNC_W;
    localparam int ITEM_LSB = POS_LSB + POS_W;
    localparam int IN_BITS  = ITEM_LSB + ITEM_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;

    // Output word: status, popped_value, result_number, list_length.
    localparam int OUT_BITS = STATUS_W + ITEM_W + NUM_W + NUM_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

endpackage

// File: hdl/ols_ram.sv
// ----------------------------------------------------------------------------
// ols_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ols_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/ordered_list_store_core.sv
// ----------------------------------------------------------------------------
// ordered_list_store_core
// Ordered list of up to DEPTH values with append, insert, remove, pop,
// index, count, reverse and clear, kept in one synchronous RAM.
// ----------------------------------------------------------------------------
// Usage: each word on the s_ stream carries one operation; each accepted word
// gives exactly one word on the m_ stream with a status, the popped value, an
// index or match count, and the list length after the operation.
// One operation is worked at a time; s_tready is high only while the
// sequencer waits for a word, which can be while a result still sits in
// the output register. A new word can be taken no earlier than the cycle
// after the previous result is registered.
// Steps per operation (n = stored length, p = position): clear, a rejected
//   operation, or any operation on a list too short to walk goes straight to
//   the result; append writes the value at the tail; insert at p shifts the
//   entries from the tail down to p up by one, then writes the value;
//   pop reads at p and shifts the entries above it down by one; count reads
//   all n entries; index stops at the first hit; remove stops at the first
//   hit and shifts the entries above it down; reverse swaps pairs from both ends.
// The single RAM read port and write port pace the work: every shift and
// search moves one entry per cycle; a swap passes S_RV_B, S_RV_C and S_RV_D.
// Reset empties the list at once; RAM contents are not cleared and are never
// read before they are written. When m_tready stays low, the finished result
// holds in the output register and the next word is accepted, but its result
// waits until the register frees.
// ----------------------------------------------------------------------------
module ordered_list_store_core #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // func[2:0], position[10:3], item_value[74:11], zero fill above
    input  logic [ols_pkg::IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // status[1:0], popped_value[65:2], result_number[72:66], list_length[79:73]
    output logic [ols_pkg::OUT_W-1:0] m_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > ols_pkg::POS_W) ? CW : ols_pkg::POS_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_SH  = 4'd1;
    localparam logic [3:0] S_INS_WR  = 4'd2;
    localparam logic [3:0] S_SCAN    = 4'd3;
    localparam logic [3:0] S_POP_RD  = 4'd4;
    localparam logic [3:0] S_POP_CAP = 4'd5;
    localparam logic [3:0] S_SHL     = 4'd6;
    localparam logic [3:0] S_SHL_END = 4'd7;
    localparam logic [3:0] S_RV_A    = 4'd8;
    localparam logic [3:0] S_RV_B    = 4'd9;
    localparam logic [3:0] S_RV_C    = 4'd10;
    localparam logic [3:0] S_RV_D    = 4'd11;
    localparam logic [3:0] S_FIN     = 4'd12;

    // Control state
    logic [3:0]                state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic                      issue_reg, issue_next;
    logic                      wp_vld_reg, wp_vld_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    // Payload
    ols_pkg::func_t            func_reg, func_next;
    logic [VALUE_WIDTH-1:0]    val_reg, val_next;
    logic [CW-1:0]             ptr_reg, ptr_next;
    logic [CW-1:0]             hi_reg, hi_next;
    logic [CW-1:0]             tgt_reg, tgt_next;
    logic [CW-1:0]             num_reg, num_next;
    logic [CW-1:0]             rd_idx_reg, rd_idx_next;
    logic [AW-1:0]             wp_addr_reg, wp_addr_next;
    ols_pkg::status_t          status_reg, status_next;
    logic [VALUE_WIDTH-1:0]    popped_reg, popped_next;
    logic [VALUE_WIDTH-1:0]    tmp_reg, tmp_next;
    logic [ols_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    // RAM port
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [VALUE_WIDTH-1:0]    mem_wdata;
    logic [AW-1:0]             mem_raddr;
    logic [VALUE_WIDTH-1:0]    mem_rdata;

    // Decoded input word
    ols_pkg::func_t            in_func;
    logic [PW-1:0]             in_pos;
    logic [VALUE_WIDTH-1:0]    in_value;
    logic [PW-1:0]             count_ext;
    logic [CW-1:0]             cnt_m1;
    logic [CW-1:0]             ins_pos;
    logic                      is_full;
    logic                      match;
    logic                      last;

    assign in_func   = s_tdata[ols_pkg::FUNC_LSB +: ols_pkg::FUNC_W];
    assign in_pos    = PW'(s_tdata[ols_pkg::POS_LSB +: ols_pkg::POS_W]);
    assign in_value  = s_tdata[ols_pkg::ITEM_LSB +: VALUE_WIDTH];
    assign count_ext = PW'(count_reg);
    assign cnt_m1    = count_reg - CW'(1);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign match     = (mem_rdata == val_reg);
    assign last      = (rd_idx_reg == cnt_m1);

    // An insert past the end lands at the end.
    assign ins_pos = (in_func == ols_pkg::FN_APPEND || in_pos > count_ext)
                     ? count_reg : CW'(in_pos);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    ols_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_vld_next   = 1'b0;
        issue_next    = issue_reg;
        wp_vld_next   = 1'b0;
        wp_addr_next  = wp_addr_reg;
        func_next     = func_reg;
        val_next      = val_reg;
        ptr_next      = ptr_reg;
        hi_next       = hi_reg;
        tgt_next      = tgt_reg;
        num_next      = num_reg;
        rd_idx_next   = rd_idx_reg;
        status_next   = status_reg;
        popped_next   = popped_reg;
        tmp_next      = tmp_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        // A shift issues a read and writes the data back in the next cycle.
        mem_raddr = ptr_reg[AW-1:0];
        mem_we    = wp_vld_reg;
        mem_waddr = wp_addr_reg;
        mem_wdata = mem_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next   = in_func;
                    val_next    = in_value;
                    status_next = ols_pkg::ST_OK;
                    popped_next = '0;
                    num_next    = '0;
                    state_next  = S_FIN;
                    case (in_func)
                        ols_pkg::FN_APPEND, ols_pkg::FN_INSERT:
                        begin
                            if (is_full)
                            begin
                                status_next = ols_pkg::ST_FULL;
                            end
                            else
                            begin
                                tgt_next   = ins_pos;
                                ptr_next   = cnt_m1;
                                state_next = (ins_pos == count_reg) ? S_INS_WR : S_INS_SH;
                            end
                        end
                        ols_pkg::FN_REMOVE, ols_pkg::FN_INDEX, ols_pkg::FN_COUNT:
                        begin
                            if (count_reg == '0)
                            begin
                                if (in_func != ols_pkg::FN_COUNT)
                                begin
                                    status_next = ols_pkg::ST_NOT_FOUND;
                                end
                            end
                            else
                            begin
                                ptr_next   = '0;
                                issue_next = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        ols_pkg::FN_POP:
                        begin
                            if (in_pos >= count_ext)
                            begin
                                status_next = ols_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ptr_next   = CW'(in_pos);
                                state_next = S_POP_RD;
                            end
                        end
                        ols_pkg::FN_REVERSE:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                ptr_next   = '0;
                                hi_next    = cnt_m1;
                                state_next = S_RV_A;
                            end
                        end
                        default:
                        begin
                            count_next = '0;
                        end
                    endcase
                end
            end

            S_INS_SH:
            begin
                wp_vld_next  = 1'b1;
                wp_addr_next = AW'(ptr_reg + CW'(1));
                if (ptr_reg == tgt_reg)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    ptr_next = ptr_reg - CW'(1);
                end
            end

            S_INS_WR:
            begin
                // Let the last shifted entry land before the new value goes in.
                if (!wp_vld_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = tgt_reg[AW-1:0];
                    mem_wdata  = val_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_FIN;
                end
            end

            S_SCAN:
            begin
                if (issue_reg)
                begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg;
                    if (ptr_reg == cnt_m1)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + CW'(1);
                    end
                end
                if (rd_vld_reg)
                begin
                    case (func_reg)
                        ols_pkg::FN_COUNT:
                        begin
                            if (match)
                            begin
                                num_next = num_reg + CW'(1);
                            end
                            if (last)
                            begin
                                state_next = S_FIN;
                            end
                        end
                        ols_pkg::FN_INDEX:
                        begin
                            if (match)
                            begin
                                num_next   = rd_idx_reg;
                                state_next = S_FIN;
                            end
                            else if (last)
                            begin
                                status_next = ols_pkg::ST_NOT_FOUND;
                                state_next  = S_FIN;
                            end
                        end
                        default:
                        begin
                            if (match && last)
                            begin
                                count_next = cnt_m1;
                                state_next = S_FIN;
                            end
                            else if (match)
                            begin
                                ptr_next   = rd_idx_reg + CW'(1);
                                state_next = S_SHL;
                            end
                            else if (last)
                            begin
                                status_next = ols_pkg::ST_NOT_FOUND;
                                state_next  = S_FIN;
                            end
                        end
                    endcase
                end
            end

            S_POP_RD:
            begin
                state_next = S_POP_CAP;
            end

            S_POP_CAP:
            begin
                popped_next = mem_rdata;
                if (ptr_reg == cnt_m1)
                begin
                    count_next = cnt_m1;
                    state_next = S_FIN;
                end
                else
                begin
                    ptr_next   = ptr_reg + CW'(1);
                    state_next = S_SHL;
                end
            end

            S_SHL:
            begin
                wp_vld_next  = 1'b1;
                wp_addr_next = AW'(ptr_reg - CW'(1));
                if (ptr_reg == cnt_m1)
                begin
                    state_next = S_SHL_END;
                end
                else
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
            end

            S_SHL_END:
            begin
                count_next = cnt_m1;
                state_next = S_FIN;
            end

            S_RV_A:
            begin
                state_next = S_RV_B;
            end

            S_RV_B:
            begin
                mem_raddr  = hi_reg[AW-1:0];
                tmp_next   = mem_rdata;
                state_next = S_RV_C;
            end

            S_RV_C:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg[AW-1:0];
                mem_wdata  = mem_rdata;
                state_next = S_RV_D;
            end

            S_RV_D:
            begin
                mem_we    = 1'b1;
                mem_waddr = hi_reg[AW-1:0];
                mem_wdata = tmp_reg;
                ptr_next  = ptr_reg + CW'(1);
                hi_next   = hi_reg - CW'(1);
                mem_raddr = AW'(ptr_reg + CW'(1));
                if (ptr_reg + CW'(2) < hi_reg)
                begin
                    state_next = S_RV_B;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = ols_pkg::OUT_W'({7'(count_reg), 7'(num_reg),
                                                    64'(popped_reg), status_reg});
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            issue_reg    <= 1'b0;
            wp_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_vld_reg   <= rd_vld_next;
            issue_reg    <= issue_next;
            wp_vld_reg   <= wp_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        val_reg     <= val_next;
        ptr_reg     <= ptr_next;
        hi_reg      <= hi_next;
        tgt_reg     <= tgt_next;
        num_reg     <= num_next;
        rd_idx_reg  <= rd_idx_next;
        wp_addr_reg <= wp_addr_next;
        status_reg  <= status_next;
        popped_reg  <= popped_next;
        tmp_reg     <= tmp_next;
        m_tdata_reg <= m_tdata_next;
    end

    // The length never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("list length above capacity");

    // The length moves by one entry per operation, or drops to zero on clear.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            count_reg == $past(count_reg) + CW'(1) ||
            count_reg == $past(count_reg) - CW'(1) ||
            count_reg == '0)
        else $error("list length jumped");

    // Writes stay inside the store.
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> mem_waddr < DEPTH)
        else $error("store write beyond depth");

    // A search only looks at stored entries.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && rd_vld_reg) |-> rd_idx_reg < count_reg)
        else $error("search read beyond list length");

    // No shifted entry is still on its way when a new word can enter.
    a_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !wp_vld_reg)
        else $error("write still pending at idle");

endmodule
